### sv/qsau_pkg.sv
// ----------------------------------------------------------------------------
// qsau_pkg
// Shared widths, types and saturation limits for the quaternion small-angle
// update pipeline.
// ----------------------------------------------------------------------------
package qsau_pkg;

    localparam int DATA_W = 32;
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 2 * MAG_W + 2;
    localparam int ROOT_W = MAG_W + 1;
    localparam int REM_W  = ROOT_W + 3;
    localparam int SAT_W  = DATA_W + 1;

    localparam logic [SAT_W-1:0] SAT_NEG = SAT_W'(33'h0_8000_0000);
    localparam logic [SAT_W-1:0] SAT_POS = SAT_W'(33'h0_7FFF_FFFF);

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        t_mag [3:0] mag;
        logic [3:0] neg;
        logic       deg;
    } t_side;

endpackage

### sv/qsau_if.sv
// ----------------------------------------------------------------------------
// qsau_if
// Valid/ready channels for the input pose beat and the result beat.
// ----------------------------------------------------------------------------
interface qsau_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, rot_x, rot_y, rot_z,
                    input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, rot_x, rot_y, rot_z,
                  output ready);
endinterface

interface qsau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               degenerate;

    modport source (output valid, out_x, out_y, out_z, out_w, degenerate, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, degenerate, output ready);
endinterface

### sv/qsau_prod.sv
// ----------------------------------------------------------------------------
// qsau_prod
// Hamilton product of the input quaternion with the half-angle delta, in two
// stages: partial products, then cross-term sums and the unit term.
// ----------------------------------------------------------------------------
module qsau_prod
    import qsau_pkg::*;
#(
    parameter int FRAC_BITS = 30,
    localparam int PW = 65 - FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [DATA_W-1:0] i_quat [4],
    input  logic signed [DATA_W-1:0] i_rot  [3],
    output logic                     o_valid,
    output logic signed [PW-1:0]     o_p    [4]
);

    localparam int MW = 2 * DATA_W - 1;
    localparam int SW = 2 * DATA_W;

    logic signed [DATA_W-2:0] d [3];
    logic signed [MW-1:0]     r_m [12];
    logic signed [DATA_W-1:0] r_q [4];
    logic                     r_vld1;
    logic signed [SW-1:0]     s [4];
    logic signed [SW-1:0]     sh [4];
    logic signed [PW-1:0]     n_p [4];
    logic signed [PW-1:0]     r_p [4];
    logic                     r_vld2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i] = i_rot[i][DATA_W-1:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= i_quat[3] * d[0];
            r_m[1]  <= i_quat[1] * d[2];
            r_m[2]  <= i_quat[2] * d[1];
            r_m[3]  <= i_quat[3] * d[1];
            r_m[4]  <= i_quat[0] * d[2];
            r_m[5]  <= i_quat[2] * d[0];
            r_m[6]  <= i_quat[3] * d[2];
            r_m[7]  <= i_quat[0] * d[1];
            r_m[8]  <= i_quat[1] * d[0];
            r_m[9]  <= i_quat[0] * d[0];
            r_m[10] <= i_quat[1] * d[1];
            r_m[11] <= i_quat[2] * d[2];
            r_q     <= i_quat;
        end
    end

    always_comb begin
        s[0] = SW'(r_m[0]) + SW'(r_m[1]) - SW'(r_m[2]);
        s[1] = SW'(r_m[3]) - SW'(r_m[4]) + SW'(r_m[5]);
        s[2] = SW'(r_m[6]) + SW'(r_m[7]) - SW'(r_m[8]);
        s[3] = -SW'(r_m[9]) - SW'(r_m[10]) - SW'(r_m[11]);
        for (int i = 0; i < 4; i++) begin
            sh[i]  = s[i] >>> FRAC_BITS;
            n_p[i] = PW'(r_q[i]) + $signed(sh[i][PW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    assign o_valid = r_vld2;
    assign o_p     = r_p;

endmodule

### sv/qsau_scale.sv
// ----------------------------------------------------------------------------
// qsau_scale
// Magnitudes, block scaling to a common exponent, squares and the squared
// norm, over five register stages.
// ----------------------------------------------------------------------------
module qsau_scale
    import qsau_pkg::*;
#(
    parameter int PW = 35
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [PW-1:0] i_p [4],
    output logic                 o_valid,
    output logic [SQ_W-1:0]      o_n2,
    output t_side                o_side
);

    localparam int LW = $clog2(PW);
    localparam logic [LW-1:0] TOP_BIT = LW'(MAG_W - 1);

    logic [PW-1:0]       r_mag_a [4];
    logic [3:0]          r_neg_a;
    logic [PW-1:0]       orv;
    logic [LW-1:0]       n_lead;
    logic [PW-1:0]       r_mag_b [4];
    logic [3:0]          r_neg_b;
    logic [LW-1:0]       r_lead;
    logic                r_zero;
    logic [PW-1:0]       shv [4];
    t_side               n_side;
    t_side               r_side_c;
    logic [2*MAG_W-1:0]  r_sq [4];
    t_side               r_side_d;
    logic [SQ_W-1:0]     r_n2;
    t_side               r_side_e;
    logic [4:0]          r_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_mag_a[i] <= i_p[i][PW-1] ? PW'(-i_p[i]) : PW'(i_p[i]);
                r_neg_a[i] <= i_p[i][PW-1];
            end
        end
    end

    always_comb begin
        orv    = r_mag_a[0] | r_mag_a[1] | r_mag_a[2] | r_mag_a[3];
        n_lead = '0;
        for (int b = 0; b < PW; b++) begin
            if (orv[b]) begin
                n_lead = LW'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_b <= r_mag_a;
            r_neg_b <= r_neg_a;
            r_lead  <= n_lead;
            r_zero  <= (orv == '0);
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_lead >= TOP_BIT) begin
                shv[i] = r_mag_b[i] >> (r_lead - TOP_BIT);
            end else begin
                shv[i] = r_mag_b[i] << (TOP_BIT - r_lead);
            end
            n_side.mag[i] = shv[i][MAG_W-1:0];
        end
        n_side.neg = r_neg_b;
        n_side.deg = r_zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_c <= n_side;
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= r_side_c.mag[i] * r_side_c.mag[i];
            end
            r_side_d <= r_side_c;
            r_n2     <= SQ_W'(r_sq[0]) + SQ_W'(r_sq[1]) + SQ_W'(r_sq[2]) + SQ_W'(r_sq[3]);
            r_side_e <= r_side_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    assign o_valid = r_vld[4];
    assign o_n2    = r_n2;
    assign o_side  = r_side_e;

endmodule

### sv/qsau_sqrt.sv
// ----------------------------------------------------------------------------
// qsau_sqrt
// Floor square root of the squared norm, one root bit per register stage.
// ----------------------------------------------------------------------------
module qsau_sqrt
    import qsau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_n2,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SQ_W-1:0]   r_n    [ROOT_W];
    t_side             r_side [ROOT_W];
    logic              r_vld  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [SQ_W-1:0]   p_n;
        t_side             p_side;
        logic              p_vld;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_n    = i_n2;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_n    = r_n[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        assign cur   = {p_rem[REM_W-3:0], p_n[SQ_W-1:SQ_W-2]};
        assign trial = REM_W'({p_root, 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (cur - trial) : cur;
                r_root[k] <= {p_root[ROOT_W-2:0], ge};
                r_n[k]    <= {p_n[SQ_W-3:0], 2'b00};
                r_side[k] <= p_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

### sv/qsau_div.sv
// ----------------------------------------------------------------------------
// qsau_div
// Rounded division of the four scaled magnitudes by the norm root, one
// quotient bit per register stage, all four lanes sharing the divisor.
// ----------------------------------------------------------------------------
module qsau_div
    import qsau_pkg::*;
#(
    parameter int FRAC_BITS = 30,
    localparam int QW = FRAC_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ROOT_W-1:0] i_root,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_q [4],
    output logic [3:0]        o_neg,
    output logic              o_deg
);

    localparam int NW = MAG_W + 1 + FRAC_BITS;

    logic [NW-1:0]     num [4];
    logic [ROOT_W-1:0] r_rem  [QW+1][4];
    logic [QW-1:0]     r_qn   [QW+1][4];
    logic [ROOT_W-1:0] r_root [QW+1];
    logic [3:0]        r_neg  [QW+1];
    logic              r_deg  [QW+1];
    logic              r_vld  [QW+1];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num[i] = {1'b0, i_side.mag[i], {FRAC_BITS{1'b0}}} + NW'(i_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_rem[0][i] <= ROOT_W'(num[i][NW-1:QW]);
                r_qn[0][i]  <= num[i][QW-1:0];
            end
            r_root[0] <= i_root;
            r_neg[0]  <= i_side.neg;
            r_deg[0]  <= i_side.deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [ROOT_W:0] cur [4];
        logic [ROOT_W:0] dif [4];
        logic [3:0]      ge;

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                cur[i] = {r_rem[k-1][i], r_qn[k-1][i][QW-1]};
                ge[i]  = (cur[i] >= {1'b0, r_root[k-1]});
                dif[i] = cur[i] - {1'b0, r_root[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 4; i++) begin
                    r_rem[k][i] <= ge[i] ? dif[i][ROOT_W-1:0] : cur[i][ROOT_W-1:0];
                    r_qn[k][i]  <= {r_qn[k-1][i][QW-2:0], ge[i]};
                end
                r_root[k] <= r_root[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_deg[k]  <= r_deg[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_q     = r_qn[QW];
    assign o_neg   = r_neg[QW];
    assign o_deg   = r_deg[QW];

endmodule

### sv/quaternion_small_angle_update.sv
// ----------------------------------------------------------------------------
// quaternion_small_angle_update
// Small-angle retraction: multiplies a unit quaternion by the delta
// [1, rot/2] on the right, normalizes the product and saturates it to Q2.30.
//
// The input channel takes one beat per pose (quaternion and rotation vector);
// the output channel returns one beat per pose with the normalized quaternion
// and a degenerate flag, set when the product is all zeros and passed through.
// The pipeline accepts a beat in every cycle unless the output stalls. Its
// stages are two product stages, five scaling and norm stages, one stage per
// root bit of the square root, one setup stage plus one stage per quotient
// bit of the divider, and the output register.
// Reset clears every valid bit, so no beat is in flight afterwards.
// When the receiver holds ready low with a beat waiting, the whole pipeline
// freezes and input ready falls; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_small_angle_update
    import qsau_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qsau_in_if.sink    i_in,
    qsau_out_if.source o_out
);

    localparam int PW = 65 - FRAC_BITS;
    localparam int QW = FRAC_BITS + 2;

    logic                     en;
    logic signed [DATA_W-1:0] quat [4];
    logic signed [DATA_W-1:0] rot  [3];
    logic                     prod_vld;
    logic signed [PW-1:0]     prod_p [4];
    logic                     scl_vld;
    logic [SQ_W-1:0]          scl_n2;
    t_side                    scl_side;
    logic                     sqrt_vld;
    logic [ROOT_W-1:0]        sqrt_root;
    t_side                    sqrt_side;
    logic                     div_vld;
    logic [QW-1:0]            div_q [4];
    logic [3:0]               div_neg;
    logic                     div_deg;
    logic [SAT_W-1:0]         mq [4];
    logic [DATA_W-1:0]        n_out [4];
    logic [DATA_W-1:0]        r_out [4];
    logic                     r_deg;
    logic                     r_out_vld;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    assign quat[0] = i_in.quat_x;
    assign quat[1] = i_in.quat_y;
    assign quat[2] = i_in.quat_z;
    assign quat[3] = i_in.quat_w;
    assign rot[0]  = i_in.rot_x;
    assign rot[1]  = i_in.rot_y;
    assign rot[2]  = i_in.rot_z;

    qsau_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_quat  (quat),
        .i_rot   (rot),
        .o_valid (prod_vld),
        .o_p     (prod_p)
    );

    qsau_scale #(.PW(PW)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prod_vld),
        .i_p     (prod_p),
        .o_valid (scl_vld),
        .o_n2    (scl_n2),
        .o_side  (scl_side)
    );

    qsau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (scl_vld),
        .i_n2    (scl_n2),
        .i_side  (scl_side),
        .o_valid (sqrt_vld),
        .o_root  (sqrt_root),
        .o_side  (sqrt_side)
    );

    qsau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sqrt_vld),
        .i_root  (sqrt_root),
        .i_side  (sqrt_side),
        .o_valid (div_vld),
        .o_q     (div_q),
        .o_neg   (div_neg),
        .o_deg   (div_deg)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mq[i] = SAT_W'(div_q[i]);
            if (div_deg) begin
                n_out[i] = '0;
            end else if (div_neg[i]) begin
                if (mq[i] > SAT_NEG) begin
                    mq[i] = SAT_NEG;
                end
                n_out[i] = DATA_W'(-mq[i]);
            end else begin
                if (mq[i] > SAT_POS) begin
                    mq[i] = SAT_POS;
                end
                n_out[i] = mq[i][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
            r_deg <= div_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_x      = r_out[0];
    assign o_out.out_y      = r_out[1];
    assign o_out.out_z      = r_out[2];
    assign o_out.out_w      = r_out[3];
    assign o_out.degenerate = r_deg;

endmodule

### bench/tb_quaternion_small_angle_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_small_angle_update
// Sends pose beats through the small-angle update pipeline and checks every
// result beat against a predictor built from 64-bit integer arithmetic. It
// covers directed extremes, zero products, near-unit poses with small
// rotations, fully random patterns and a stretch without idling on either side.
// ----------------------------------------------------------------------------
module tb_quaternion_small_angle_update;
    import qsau_pkg::*;

    localparam int FRAC = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 38;

    typedef struct {
        logic signed [31:0] qx, qy, qz, qw;
        logic               deg;
    } t_pose_out;

    logic i_clk;
    logic i_rst_n;

    qsau_in_if  pose_ch();
    qsau_out_if result_ch();

    quaternion_small_angle_update #(.FRAC_BITS(FRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pose_ch),
        .o_out  (result_ch)
    );

    t_pose_out pending_poses[$];
    int        mismatches;
    int        beats_sent;
    int        beats_checked;
    int        degenerate_seen;
    int        cycles;
    bit        idle_on;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned step;
        res = 0;
        step = 64'd1 << 62;
        while (step > n) step >>= 2;
        while (step != 0) begin
            if (n >= res + step) begin
                n -= res + step;
                res = (res >> 1) + step;
            end else begin
                res >>= 1;
            end
            step >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp_q(input bit neg,
                                                   input longint unsigned mag);
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return 32'(-$signed(mag[32:0]));
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic t_pose_out retract_pose(input logic signed [31:0] qx, qy, qz, qw,
                                               input logic signed [31:0] rx, ry, rz);
        longint          x, y, z, w, dx, dy, dz;
        longint          prod[4];
        longint unsigned mag[4];
        bit              neg[4];
        longint unsigned peak, n2, root;
        t_pose_out       res;
        x = qx; y = qy; z = qz; w = qw;
        dx = longint'(rx) >>> 1;
        dy = longint'(ry) >>> 1;
        dz = longint'(rz) >>> 1;
        prod[0] = x + ((w * dx + y * dz - z * dy) >>> FRAC);
        prod[1] = y + ((w * dy - x * dz + z * dx) >>> FRAC);
        prod[2] = z + ((w * dz + x * dy - y * dx) >>> FRAC);
        prod[3] = w + ((-(x * dx) - y * dy - z * dz) >>> FRAC);
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = prod[i] < 0;
            mag[i] = neg[i] ? -prod[i] : prod[i];
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak == 0) begin
            res.qx = 0; res.qy = 0; res.qz = 0; res.qw = 0; res.deg = 1'b1;
            return res;
        end
        while (peak >= (64'd1 << 30)) begin
            peak >>= 1;
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
        end
        while (peak < (64'd1 << 29)) begin
            peak <<= 1;
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
        end
        n2 = 0;
        for (int i = 0; i < 4; i++) n2 += mag[i] * mag[i];
        root = root_floor(n2);
        if (root == 0) root = 1;
        for (int i = 0; i < 4; i++) mag[i] = ((mag[i] << FRAC) + (root >> 1)) / root;
        res.qx = clamp_q(neg[0], mag[0]);
        res.qy = clamp_q(neg[1], mag[1]);
        res.qz = clamp_q(neg[2], mag[2]);
        res.qw = clamp_q(neg[3], mag[3]);
        res.deg = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH beat %0d %s: got %h want %h", beats_checked, what, got, want);
        mismatches++;
    endtask

    task automatic send_pose(input logic signed [31:0] qx, qy, qz, qw,
                             input logic signed [31:0] rx, ry, rz);
        pose_ch.valid  <= 1'b1;
        pose_ch.quat_x <= qx;
        pose_ch.quat_y <= qy;
        pose_ch.quat_z <= qz;
        pose_ch.quat_w <= qw;
        pose_ch.rot_x  <= rx;
        pose_ch.rot_y  <= ry;
        pose_ch.rot_z  <= rz;
        do @(posedge i_clk); while (!pose_ch.ready);
        pending_poses.push_back(retract_pose(qx, qy, qz, qw, rx, ry, rz));
        beats_sent++;
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            pose_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
    endtask

    function automatic logic signed [31:0] near_unit();
        return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    endfunction

    function automatic logic signed [31:0] small_rot();
        return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    task automatic test_directed_extremes();
        logic signed [31:0] lo, hi, one;
        lo = 32'sh8000_0000;
        hi = 32'sh7FFF_FFFF;
        one = 32'sh4000_0000;
        send_pose(0, 0, 0, one, 0, 0, 0);
        send_pose(one, 0, 0, 0, 0, 0, 0);
        send_pose(0, 0, 0, -one, one, -one, one);
        send_pose(0, 0, 0, one, 1, -1, 3);
        send_pose(0, 0, 0, one, -1, -1, -1);
        send_pose(hi, hi, hi, hi, hi, hi, hi);
        send_pose(lo, lo, lo, lo, lo, lo, lo);
        send_pose(lo, hi, lo, hi, hi, lo, hi);
        send_pose(hi, lo, hi, lo, lo, hi, lo);
        send_pose(1, 0, 0, 0, 0, 0, 0);
        send_pose(-1, 1, -1, 1, -1, 1, -1);
        send_pose(32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000,
                  32'sh0010_0000, -32'sh0020_0000, 32'sh0000_0400);
        send_pose(0, 0, 0, one, hi, 0, lo);
        send_pose(-1, -1, -1, -1, 0, 0, 0);
    endtask

    task automatic test_zero_product();
        send_pose(0, 0, 0, 0, 0, 0, 0);
        send_pose(0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
        send_pose(0, 0, 0, 0, -1, -1, -1);
    endtask

    task automatic test_unit_small_rotation(input int count);
        for (int i = 0; i < count; i++)
            send_pose(near_unit(), near_unit(), near_unit(), near_unit(),
                      small_rot(), small_rot(), small_rot());
    endtask

    task automatic test_random_patterns(input int count);
        for (int i = 0; i < count; i++)
            send_pose($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i % 2 == 0)
                send_pose(near_unit(), near_unit(), near_unit(), near_unit(),
                          $urandom, $urandom, $urandom);
            else
                send_pose($urandom, $urandom, $urandom, $urandom,
                          small_rot(), small_rot(), small_rot());
        end
        idle_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_pose_out want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_poses.size() == 0) begin
                $display("UNEXPECTED result beat after %0d checked", beats_checked);
                mismatches++;
            end else begin
                want = pending_poses.pop_front();
                if (result_ch.out_x !== want.qx) report_mismatch("out_x", result_ch.out_x, want.qx);
                if (result_ch.out_y !== want.qy) report_mismatch("out_y", result_ch.out_y, want.qy);
                if (result_ch.out_z !== want.qz) report_mismatch("out_z", result_ch.out_z, want.qz);
                if (result_ch.out_w !== want.qw) report_mismatch("out_w", result_ch.out_w, want.qw);
                if (result_ch.degenerate !== want.deg)
                    report_mismatch("degenerate", 32'(result_ch.degenerate), 32'(want.deg));
                if (want.deg) degenerate_seen++;
            end
            beats_checked++;
        end
        result_ch.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats outstanding", cycles,
                     pending_poses.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        beats_sent = 0;
        idle_on = 1'b1;
        i_rst_n <= 1'b0;
        pose_ch.valid <= 1'b0;
        pose_ch.quat_x <= '0;
        pose_ch.quat_y <= '0;
        pose_ch.quat_z <= '0;
        pose_ch.quat_w <= '0;
        pose_ch.rot_x <= '0;
        pose_ch.rot_y <= '0;
        pose_ch.rot_z <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_zero_product();
        test_unit_small_rotation(450);
        test_back_to_back(150);
        test_random_patterns(300);
        pose_ch.valid <= 1'b0;

        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (FRAC + 60) @(posedge i_clk);

        $display("Sent %0d pose beats, checked %0d results (%0d degenerate).",
                 beats_sent, beats_checked, degenerate_seen);
        $display("Covered extremes, zero products, near-unit poses and raw patterns.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
sv/qsau_pkg.sv
sv/qsau_if.sv
sv/qsau_prod.sv
sv/qsau_scale.sv
sv/qsau_sqrt.sv
sv/qsau_div.sv
sv/quaternion_small_angle_update.sv
bench/tb_quaternion_small_angle_update.sv
